// ===== sv/ith_pkg.sv =====
// Shared constants, types and tables for the IMU tilt and heading unit.
package ith_pkg;

  // Default number of CORDIC vectoring steps (legal range 8..24)
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  // Iterations of the bitwise integer square root (64-bit radicand)
  localparam int unsigned SQRT_ITERS = 32;
  // CORDIC datapath width for x/y and angle accumulator width
  localparam int unsigned CW = 34;
  localparam int unsigned ZW = 30;

  // Angles in degrees * 2^20
  localparam logic signed [ZW-1:0] HALF_TURN    = 30'sd188743680;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 30'sd94371840;
  // Full circle in 1/128 degree
  localparam logic [15:0] HEAD_FULL = 16'd46080;
  localparam logic [14:0] PITCH_LIM = 15'd11520;
  localparam logic [14:0] ROLL_LIM  = 15'd23040;

  // Register reset values
  localparam logic [14:0] ACCEL_SCALE_RST = 15'd4096;
  localparam logic [21:0] GYRO_SCALE_RST  = 22'd511531;

  // Configuration register indexes
  typedef enum logic {
    REG_ACCEL_SCALE = 1'b0,
    REG_GYRO_SCALE  = 1'b1
  } cfg_reg_e;

  // Side data carried alongside the square root pipeline
  typedef struct packed {
    logic signed [20:0] rate_x;
    logic signed [20:0] rate_y;
    logic signed [20:0] rate_z;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic               present;
  } sqrt_side_t;

  // Side data carried alongside the CORDIC pipeline
  typedef struct packed {
    logic signed [20:0] rate_x;
    logic signed [20:0] rate_y;
    logic signed [20:0] rate_z;
    logic [21:0]        mag;
    logic               present;
  } cordic_side_t;

  // atan(2^-i) in degrees * 2^20
  function automatic logic [25:0] atan_entry(input logic [4:0] i);
    logic [25:0] v;
    unique case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ith_sqrt_pipe.sv =====
// Two-lane pipelined bitwise integer square root, one iteration per stage.
module ith_sqrt_pipe #(
  parameter int unsigned SideW = 1
) (
  input  logic                            clk_i,
  input  logic [ith_pkg::SQRT_ITERS-1:0]  en_i,
  input  logic [63:0]                     a_i,
  input  logic [63:0]                     b_i,
  input  logic [SideW-1:0]                side_i,
  output logic [31:0]                     root_a_o,
  output logic [31:0]                     root_b_o,
  output logic [SideW-1:0]                side_o
);

  localparam int unsigned Iters = ith_pkg::SQRT_ITERS;

  logic [63:0]      na_q   [Iters];
  logic [63:0]      ra_q   [Iters];
  logic [63:0]      nb_q   [Iters];
  logic [63:0]      rb_q   [Iters];
  logic [SideW-1:0] side_q [Iters];

  for (genvar j = 0; j < Iters; j++) begin : g_it
    localparam logic [63:0] BitJ = 64'd1 << (62 - 2 * j);
    logic [63:0]      na_in, ra_in, nb_in, rb_in, ta, tb;
    logic [SideW-1:0] s_in;

    if (j == 0) begin : g_first
      assign na_in = a_i;
      assign nb_in = b_i;
      assign ra_in = '0;
      assign rb_in = '0;
      assign s_in  = side_i;
    end else begin : g_next
      assign na_in = na_q[j-1];
      assign nb_in = nb_q[j-1];
      assign ra_in = ra_q[j-1];
      assign rb_in = rb_q[j-1];
      assign s_in  = side_q[j-1];
    end

    assign ta = ra_in + BitJ;
    assign tb = rb_in + BitJ;

    // one restoring root step per lane
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        side_q[j] <= s_in;
        if (na_in >= ta) begin
          na_q[j] <= na_in - ta;
          ra_q[j] <= (ra_in >> 1) + BitJ;
        end else begin
          na_q[j] <= na_in;
          ra_q[j] <= ra_in >> 1;
        end
        if (nb_in >= tb) begin
          nb_q[j] <= nb_in - tb;
          rb_q[j] <= (rb_in >> 1) + BitJ;
        end else begin
          nb_q[j] <= nb_in;
          rb_q[j] <= rb_in >> 1;
        end
      end
    end
  end

  assign root_a_o = ra_q[Iters-1][31:0];
  assign root_b_o = rb_q[Iters-1][31:0];
  assign side_o   = side_q[Iters-1];

endmodule

// ===== sv/ith_cordic_pipe.sv =====
// Three-lane pipelined CORDIC atan2 (vectoring), one step per stage.
module ith_cordic_pipe #(
  parameter int unsigned Steps = ith_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SideW = 1
) (
  input  logic                              clk_i,
  input  logic [Steps:0]                    en_i,
  input  logic signed [ith_pkg::CW-1:0]     x_i [3],
  input  logic signed [ith_pkg::CW-1:0]     y_i [3],
  input  logic [SideW-1:0]                  side_i,
  output logic signed [ith_pkg::ZW-1:0]     z_o [3],
  output logic [SideW-1:0]                  side_o
);

  localparam int unsigned Cw = ith_pkg::CW;
  localparam int unsigned Zw = ith_pkg::ZW;

  logic signed [Cw-1:0] x_q    [Steps+1][3];
  logic signed [Cw-1:0] y_q    [Steps+1][3];
  logic signed [Zw-1:0] z_q    [Steps+1][3];
  logic                 zero_q [Steps+1][3];
  logic [SideW-1:0]     side_q [Steps+1];

  // Pre-rotation into the right half plane, zero vector flagged
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= side_i;
      for (int l = 0; l < 3; l++) begin
        zero_q[0][l] <= (x_i[l] == '0) && (y_i[l] == '0);
        if (x_i[l] < 0) begin
          if (y_i[l] >= 0) begin
            x_q[0][l] <= y_i[l];
            y_q[0][l] <= -x_i[l];
            z_q[0][l] <= ith_pkg::QUARTER_TURN;
          end else begin
            x_q[0][l] <= -y_i[l];
            y_q[0][l] <= x_i[l];
            z_q[0][l] <= -ith_pkg::QUARTER_TURN;
          end
        end else begin
          x_q[0][l] <= x_i[l];
          y_q[0][l] <= y_i[l];
          z_q[0][l] <= '0;
        end
      end
    end
  end

  // Vectoring steps
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    localparam logic signed [Zw-1:0] Atan =
      $signed(Zw'(ith_pkg::atan_entry(5'(s - 1))));
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < 3; l++) begin
          zero_q[s][l] <= zero_q[s-1][l];
          if (y_q[s-1][l] >= 0) begin
            x_q[s][l] <= x_q[s-1][l] + (y_q[s-1][l] >>> (s - 1));
            y_q[s][l] <= y_q[s-1][l] - (x_q[s-1][l] >>> (s - 1));
            z_q[s][l] <= z_q[s-1][l] + Atan;
          end else begin
            x_q[s][l] <= x_q[s-1][l] - (y_q[s-1][l] >>> (s - 1));
            y_q[s][l] <= y_q[s-1][l] + (x_q[s-1][l] >>> (s - 1));
            z_q[s][l] <= z_q[s-1][l] - Atan;
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      z_o[l] = zero_q[Steps][l] ? '0 : z_q[Steps][l];
    end
  end
  assign side_o = side_q[Steps];

endmodule

// ===== sv/imu_tilt_heading_unit.sv =====
// Top level: gyro rate scaling, acceleration magnitude, pitch, roll and heading.
// Throughput: one item per cycle unless the output stalls; every stage holds a valid
// bit and bubbles collapse. The depth comes mostly from the 32-stage square root and
// the CORDIC chain: a pre-rotation stage, then CORDIC_STEPS vectoring stages.
// Reset clears all valid bits and loads accel_scale = 4096, gyro_scale = 511531.
module imu_tilt_heading_unit #(
  parameter int unsigned CORDIC_STEPS = ith_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y
  input  logic [127:0] s_axis_tdata,
  // mag_present
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rate_x, rate_y, rate_z, accel_magnitude, pitch_angle, roll_angle,
  // heading_angle, zero pad
  output logic [135:0] m_axis_tdata,
  // heading_valid
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [21:0]  cfg_data_i
);

  localparam int unsigned Cw      = ith_pkg::CW;
  localparam int unsigned Zw      = ith_pkg::ZW;
  localparam int unsigned SqrtPos = 3;
  localparam int unsigned CordPos = SqrtPos + ith_pkg::SQRT_ITERS;
  localparam int unsigned P1Pos   = CordPos + CORDIC_STEPS + 1;
  localparam int unsigned OutPos  = P1Pos + 1;
  localparam int unsigned NStages = OutPos + 1;
  localparam int unsigned SqSideW = $bits(ith_pkg::sqrt_side_t);
  localparam int unsigned CoSideW = $bits(ith_pkg::cordic_side_t);

  // Configuration registers
  logic [14:0] accel_scale_q;
  logic [21:0] gyro_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_scale_q <= ith_pkg::ACCEL_SCALE_RST;
      gyro_scale_q  <= ith_pkg::GYRO_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (ith_pkg::cfg_reg_e'(cfg_idx_i))
        ith_pkg::REG_ACCEL_SCALE: accel_scale_q <= cfg_data_i[14:0];
        ith_pkg::REG_GYRO_SCALE:  gyro_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance enables
  logic [NStages-1:0] vld_q;
  logic [NStages-1:0] en;

  assign en[NStages-1] = !vld_q[NStages-1] || m_axis_tready;
  for (genvar k = 0; k < NStages - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // Round to nearest (halves away from zero) by 2^16 and saturate to 21 bits
  function automatic logic signed [20:0] rate_round(input logic signed [38:0] p);
    logic [38:0] m;
    logic [22:0] q;
    logic signed [20:0] r;
    m = (p < 0) ? 39'(-p) : 39'(p);
    q = 23'((m + 39'd32768) >> 16);
    if (p < 0) begin
      r = (q > 23'd1048576) ? -21'sd1048576 : 21'(-$signed({1'b0, q}));
    end else begin
      r = (q > 23'd1048575) ? 21'sd1048575 : $signed(21'(q));
    end
    return r;
  endfunction

  // Stage 1: scale products
  logic signed [31:0] ax1_d, ay1_d, az1_d;
  logic signed [38:0] gx1_d, gy1_d, gz1_d;
  logic signed [31:0] ax1_q, ay1_q, az1_q;
  logic signed [38:0] gx1_q, gy1_q, gz1_q;
  logic signed [15:0] mx1_q, my1_q;
  logic               pres1_q;

  assign ax1_d = $signed(s_axis_tdata[15:0])   * $signed({1'b0, accel_scale_q});
  assign ay1_d = $signed(s_axis_tdata[31:16])  * $signed({1'b0, accel_scale_q});
  assign az1_d = $signed(s_axis_tdata[47:32])  * $signed({1'b0, accel_scale_q});
  assign gx1_d = $signed(s_axis_tdata[63:48])  * $signed({1'b0, gyro_scale_q});
  assign gy1_d = $signed(s_axis_tdata[79:64])  * $signed({1'b0, gyro_scale_q});
  assign gz1_d = $signed(s_axis_tdata[95:80])  * $signed({1'b0, gyro_scale_q});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax1_q   <= ax1_d;
      ay1_q   <= ay1_d;
      az1_q   <= az1_d;
      gx1_q   <= gx1_d;
      gy1_q   <= gy1_d;
      gz1_q   <= gz1_d;
      mx1_q   <= $signed(s_axis_tdata[111:96]);
      my1_q   <= $signed(s_axis_tdata[127:112]);
      pres1_q <= s_axis_tuser;
    end
  end

  // Stage 2: squares and rounded rates
  logic signed [63:0] sqx2_d, sqy2_d, sqz2_d;
  logic [63:0]        sqx2_q, sqy2_q, sqz2_q;
  logic signed [31:0] ax2_q, ay2_q, az2_q;
  logic signed [20:0] rx2_q, ry2_q, rz2_q;
  logic signed [15:0] mx2_q, my2_q;
  logic               pres2_q;

  assign sqx2_d = ax1_q * ax1_q;
  assign sqy2_d = ay1_q * ay1_q;
  assign sqz2_d = az1_q * az1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sqx2_q  <= sqx2_d;
      sqy2_q  <= sqy2_d;
      sqz2_q  <= sqz2_d;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      az2_q   <= az1_q;
      rx2_q   <= rate_round(gx1_q);
      ry2_q   <= rate_round(gy1_q);
      rz2_q   <= rate_round(gz1_q);
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      pres2_q <= pres1_q;
    end
  end

  // Stage 3: sums of squares
  logic [63:0]         sxy3_q, sum3_q;
  ith_pkg::sqrt_side_t side3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sxy3_q          <= sqx2_q + sqy2_q;
      sum3_q          <= sqx2_q + sqy2_q + sqz2_q;
      side3_q.rate_x  <= rx2_q;
      side3_q.rate_y  <= ry2_q;
      side3_q.rate_z  <= rz2_q;
      side3_q.ax      <= ax2_q;
      side3_q.ay      <= ay2_q;
      side3_q.az      <= az2_q;
      side3_q.mx      <= mx2_q;
      side3_q.my      <= my2_q;
      side3_q.present <= pres2_q;
    end
  end

  // Square roots of the full and horizontal sums
  logic [31:0]         root_sum, root_xy;
  logic [SqSideW-1:0]  sq_side_raw;
  ith_pkg::sqrt_side_t sq_side;

  ith_sqrt_pipe #(
    .SideW (SqSideW)
  ) u_sqrt (
    .clk_i    (clk_i),
    .en_i     (en[SqrtPos +: ith_pkg::SQRT_ITERS]),
    .a_i      (sum3_q),
    .b_i      (sxy3_q),
    .side_i   (side3_q),
    .root_a_o (root_sum),
    .root_b_o (root_xy),
    .side_o   (sq_side_raw)
  );

  assign sq_side = ith_pkg::sqrt_side_t'(sq_side_raw);

  // Magnitude rounding to 1/65536 g with saturation, CORDIC lane setup
  logic [24:0]           mag_r;
  ith_pkg::cordic_side_t co_side_in;
  logic signed [Cw-1:0]  cx [3];
  logic signed [Cw-1:0]  cy [3];

  assign mag_r = 25'(({1'b0, root_sum} + 33'd128) >> 8);

  always_comb begin
    co_side_in.rate_x  = sq_side.rate_x;
    co_side_in.rate_y  = sq_side.rate_y;
    co_side_in.rate_z  = sq_side.rate_z;
    co_side_in.mag     = (mag_r > 25'd4194303) ? 22'd4194303 : mag_r[21:0];
    co_side_in.present = sq_side.present;
    // pitch lane: atan2(-z, sqrt(x^2 + y^2))
    cx[0] = Cw'(root_xy);
    cy[0] = -Cw'(sq_side.az);
    // roll lane: atan2(x, y)
    cx[1] = Cw'(sq_side.ay);
    cy[1] = Cw'(sq_side.ax);
    // heading lane: atan2(mag_x, mag_y), scaled by 2^14
    cx[2] = Cw'(sq_side.my) <<< 14;
    cy[2] = Cw'(sq_side.mx) <<< 14;
  end

  logic signed [Zw-1:0] cz [3];
  logic [CoSideW-1:0]    co_side_raw;
  ith_pkg::cordic_side_t co_side;

  ith_cordic_pipe #(
    .Steps (CORDIC_STEPS),
    .SideW (CoSideW)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en[CordPos +: CORDIC_STEPS + 1]),
    .x_i    (cx),
    .y_i    (cy),
    .side_i (co_side_in),
    .z_o    (cz),
    .side_o (co_side_raw)
  );

  assign co_side = ith_pkg::cordic_side_t'(co_side_raw);

  // Post stage 1: clamp to half turn, round magnitude to 1/128 degree
  logic [14:0]           q1_q   [3];
  logic                  neg1_q [3];
  ith_pkg::cordic_side_t side1_q;

  always_ff @(posedge clk_i) begin
    if (en[P1Pos]) begin
      side1_q <= co_side;
      for (int l = 0; l < 3; l++) begin
        logic signed [Zw-1:0] zc;
        logic [Zw-1:0]        zm;
        if (cz[l] > ith_pkg::HALF_TURN) begin
          zc = ith_pkg::HALF_TURN;
        end else if (cz[l] < -ith_pkg::HALF_TURN) begin
          zc = -ith_pkg::HALF_TURN;
        end else begin
          zc = cz[l];
        end
        zm = (zc < 0) ? Zw'(-zc) : Zw'(zc);
        q1_q[l]   <= 15'((zm + Zw'(4096)) >> 13);
        neg1_q[l] <= zc < 0;
      end
    end
  end

  // Post stage 2 (output register): sign, pitch limit, heading wrap, zero heading without mag
  logic [14:0]        qp;
  logic signed [14:0] pitch_d;
  logic signed [15:0] roll_d;
  logic [15:0]        head_d;
  logic [135:0]       tdata_q;
  logic               tuser_q;

  always_comb begin
    qp      = (q1_q[0] > ith_pkg::PITCH_LIM) ? ith_pkg::PITCH_LIM : q1_q[0];
    pitch_d = neg1_q[0] ? -$signed(qp) : $signed(qp);
    roll_d  = neg1_q[1] ? -$signed({1'b0, q1_q[1]}) : $signed({1'b0, q1_q[1]});
    if (!side1_q.present) begin
      head_d = '0;
    end else if (neg1_q[2] && (q1_q[2] != '0)) begin
      head_d = ith_pkg::HEAD_FULL - {1'b0, q1_q[2]};
    end else begin
      head_d = {1'b0, q1_q[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutPos]) begin
      tdata_q <= {4'b0000, head_d, roll_d, pitch_d, side1_q.mag,
                  side1_q.rate_z, side1_q.rate_y, side1_q.rate_x};
      tuser_q <= side1_q.present;
    end
  end

  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tvalid = vld_q[OutPos];

endmodule

// ===== sv/ith_checker.sv =====
// Port-level checker for the IMU tilt and heading unit, bound to the top level.
module ith_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [127:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         cfg_we_i,
  input logic         cfg_idx_i,
  input logic [21:0]  cfg_data_i
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // with nothing waiting at the output the pipe takes input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // heading is zero when not valid, and below a full circle otherwise
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[131:116] < 16'd46080)
                                    : (m_axis_tdata[131:116] == 16'd0)))
    else $error("heading out of range");

  // pitch within +-90 degrees
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[99:85]) <= 15'sd11520) &&
                      ($signed(m_axis_tdata[99:85]) >= -15'sd11520))
    else $error("pitch out of range");

endmodule

bind imu_tilt_heading_unit ith_checker u_ith_checker (.*);
